// ===== src/lsfr_pkg.sv =====
package lsfr_pkg;

   localparam int PIXEL_COUNT = 5;
   localparam logic [2:0] LAST_PIXEL   = 3'(PIXEL_COUNT - 1);
   localparam logic [2:0] CENTER_PIXEL = 3'(PIXEL_COUNT / 2);

   // input commands
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // effect kinds
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_SOLID   = 3'd1;
   localparam logic [2:0] KIND_RIPPLE  = 3'd2;
   localparam logic [2:0] KIND_FLOW    = 3'd3;
   localparam logic [2:0] KIND_PULSE   = 3'd4;
   localparam logic [2:0] KIND_RAINBOW = 3'd5;
   localparam logic [2:0] KIND_AGENT   = 3'd6;

   // agent states
   localparam logic [2:0] AGENT_IDLE    = 3'd0;
   localparam logic [2:0] AGENT_RUNNING = 3'd1;
   localparam logic [2:0] AGENT_WAITING = 3'd2;
   localparam logic [2:0] AGENT_UNREAD  = 3'd3;
   localparam logic [2:0] AGENT_FAILED  = 3'd4;

   // divisor codes
   localparam logic [2:0] DIV_1  = 3'd0;
   localparam logic [2:0] DIV_2  = 3'd1;
   localparam logic [2:0] DIV_4  = 3'd2;
   localparam logic [2:0] DIV_5  = 3'd3;
   localparam logic [2:0] DIV_6  = 3'd4;
   localparam logic [2:0] DIV_8  = 3'd5;
   localparam logic [2:0] DIV_12 = 3'd6;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } lsfr_rgb_type;

   typedef struct packed {
      logic [2:0]   kind;
      logic         flow_right;
      lsfr_rgb_type base;
      logic [2:0]   agent_state;
      logic [2:0]   cursor;
   } lsfr_item_type;

   typedef struct packed {
      lsfr_rgb_type color;
      logic [3:0]   numer;
      logic [2:0]   div_code;
   } lsfr_shade_type;

   function automatic logic [3:0] flow_num(input logic [2:0] gap);
      logic [3:0] n;
      case (gap)
         3'd0:    n = 4'd12;
         3'd1:    n = 4'd7;
         3'd2:    n = 4'd4;
         3'd3:    n = 4'd2;
         3'd4:    n = 4'd1;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // center weight and side weight floor(2n/3) of the pulse
   function automatic logic [3:0] pulse_num(input logic [2:0] cur, input logic center);
      logic [3:0] n;
      case (cur)
         3'd0:    n = center ? 4'd5  : 4'd3;
         3'd1:    n = center ? 4'd12 : 4'd8;
         3'd2:    n = center ? 4'd7  : 4'd4;
         3'd3:    n = center ? 4'd3  : 4'd2;
         3'd4:    n = center ? 4'd1  : 4'd0;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // ripple divisor, 0 is dark
   function automatic logic [3:0] ripple_div(input logic [1:0] phase, input logic [2:0] pix);
      logic [3:0] d;
      d = 4'd0;
      case (phase)
         2'd0: begin
            case (pix)
               3'd1, 3'd3: d = 4'd5;
               3'd2:       d = 4'd1;
               default:    d = 4'd0;
            endcase
         end
         2'd1: begin
            case (pix)
               3'd0, 3'd4: d = 4'd4;
               3'd1, 3'd3: d = 4'd1;
               3'd2:       d = 4'd2;
               default:    d = 4'd0;
            endcase
         end
         2'd2: begin
            case (pix)
               3'd0, 3'd4: d = 4'd1;
               3'd1, 3'd3: d = 4'd4;
               default:    d = 4'd0;
            endcase
         end
         default: begin
            case (pix)
               3'd0, 3'd4: d = 4'd4;
               3'd1, 3'd3: d = 4'd6;
               3'd2:       d = 4'd8;
               default:    d = 4'd0;
            endcase
         end
      endcase
      return d;
   endfunction

   function automatic logic [2:0] div_code(input logic [3:0] d);
      logic [2:0] c;
      case (d)
         4'd2:    c = DIV_2;
         4'd4:    c = DIV_4;
         4'd5:    c = DIV_5;
         4'd6:    c = DIV_6;
         4'd8:    c = DIV_8;
         4'd12:   c = DIV_12;
         default: c = DIV_1;
      endcase
      return c;
   endfunction

   function automatic lsfr_rgb_type marquee_color(input logic [2:0] idx);
      lsfr_rgb_type c;
      case (idx)
         3'd0:    c = '{red: 8'd46, green: 8'd0,  blue: 8'd5};
         3'd1:    c = '{red: 8'd46, green: 8'd17, blue: 8'd0};
         3'd2:    c = '{red: 8'd38, green: 8'd35, blue: 8'd0};
         3'd3:    c = '{red: 8'd0,  green: 8'd43, blue: 8'd11};
         3'd4:    c = '{red: 8'd0,  green: 8'd36, blue: 8'd43};
         3'd5:    c = '{red: 8'd12, green: 8'd0,  blue: 8'd47};
         3'd6:    c = '{red: 8'd42, green: 8'd0,  blue: 8'd36};
         default: c = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
      endcase
      return c;
   endfunction

   function automatic lsfr_rgb_type agent_color(input logic [2:0] st);
      lsfr_rgb_type c;
      case (st)
         AGENT_RUNNING: c = '{red: 8'd0,  green: 8'd0,  blue: 8'd28};
         AGENT_WAITING: c = '{red: 8'd30, green: 8'd12, blue: 8'd0};
         AGENT_UNREAD:  c = '{red: 8'd0,  green: 8'd24, blue: 8'd5};
         AGENT_FAILED:  c = '{red: 8'd30, green: 8'd0,  blue: 8'd8};
         default:       c = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage

// ===== src/lsfr_pixel_shader.sv =====
module lsfr_pixel_shader (
   input  lsfr_pkg::lsfr_item_type  item,
   input  logic [2:0]               pixel_idx,
   output lsfr_pkg::lsfr_shade_type shade
);
   import lsfr_pkg::*;

   logic [3:0] flow_sum;
   logic [2:0] flow_dist;
   logic [3:0] rainbow_sum;
   logic [2:0] rainbow_idx;
   logic [2:0] agent_dist;
   logic [3:0] ripple_d;

   always_comb begin
      // distance behind the flow head, wrapped around the strip
      if (item.flow_right) begin
         flow_sum = {1'b0, item.cursor} + 4'(PIXEL_COUNT) - {1'b0, pixel_idx};
      end else begin
         flow_sum = {1'b0, pixel_idx} + {1'b0, item.cursor} + 4'd1;
      end
      flow_dist = (flow_sum >= 4'(PIXEL_COUNT)) ? 3'(flow_sum - 4'(PIXEL_COUNT))
                                               : flow_sum[2:0];

      rainbow_sum = {1'b0, pixel_idx} + {1'b0, item.cursor};
      rainbow_idx = (rainbow_sum >= 4'd7) ? 3'(rainbow_sum - 4'd7) : rainbow_sum[2:0];

      agent_dist = (pixel_idx > CENTER_PIXEL) ? pixel_idx - CENTER_PIXEL
                                              : CENTER_PIXEL - pixel_idx;

      ripple_d = ripple_div(item.cursor[1:0], pixel_idx);

      shade.color    = item.base;
      shade.numer    = 4'd0;
      shade.div_code = DIV_1;

      case (item.kind)
         KIND_SOLID: begin
            shade.numer = 4'd1;
         end
         KIND_RIPPLE: begin
            shade.numer    = (ripple_d != 4'd0) ? 4'd1 : 4'd0;
            shade.div_code = div_code(ripple_d);
         end
         KIND_FLOW: begin
            shade.numer    = flow_num(flow_dist);
            shade.div_code = DIV_12;
         end
         KIND_PULSE: begin
            shade.numer    = pulse_num(item.cursor, pixel_idx == CENTER_PIXEL);
            shade.div_code = DIV_12;
         end
         KIND_RAINBOW: begin
            shade.color = marquee_color(rainbow_idx);
            shade.numer = 4'd1;
         end
         KIND_AGENT: begin
            shade.color    = agent_color(item.agent_state);
            shade.numer    = 4'd1;
            shade.div_code = (agent_dist == 3'd0) ? DIV_1 :
                             (agent_dist == 3'd1) ? DIV_2 : DIV_4;
         end
         default: begin
            shade.numer = 4'd0;
         end
      endcase
   end

endmodule

// ===== src/led_strip_effect_frame_renderer.sv =====
// each pixel passes from the held item through the product stage and output register
// throughput: one pixel per cycle while rsp is not stalled, set by the single
//   pixel counter that walks the held item through the shader
// the next item is taken in the cycle its last pixel enters the pipeline
// reset (synchronous): frame cursor to 0, all pipeline stages empty
module led_strip_effect_frame_renderer (
   input  logic        clock,
   input  logic        reset,
   // req_tuser: command[0], effect_kind[3:1]
   // req_tdata: flow_right[0], base_red[8:1], base_green[16:9],
   //            base_blue[24:17], agent_state[27:25], zero[31:28]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [3:0]  req_tuser,
   // rsp_tdata: pixel_pos[2:0], pixel_red[10:3], pixel_green[18:11],
   //            pixel_blue[26:19], zero[31:27]
   // rsp_tlast: last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);
   import lsfr_pkg::*;

   // frame cursor, updated as each item is accepted
   logic [2:0]     cursor_ff, cursor_in;

   // held item and the pixel being rendered from it
   logic           item_valid_ff, item_valid_in;
   lsfr_item_type  item_ff, item_in;
   logic [2:0]     pix_ff, pix_in;

   // product stage
   logic           s1_valid_ff, s1_valid_in;
   logic [11:0]    s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [11:0]    s1_red_in, s1_green_in, s1_blue_in;
   logic [2:0]     s1_div_ff, s1_div_in;
   logic [2:0]     s1_idx_ff, s1_idx_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [23:0]    rsp_rgb_ff, rsp_rgb_in;
   logic [2:0]     rsp_idx_ff, rsp_idx_in;

   lsfr_shade_type shade;
   logic           req_accept;
   logic           s1_load;
   logic           s2_load;
   logic           last_load;

   // floor(p / d) for the divisors the effects use; thirds by reciprocal 683/2048
   function automatic logic [7:0] scale_div(input logic [11:0] p, input logic [2:0] dc);
      logic [19:0] m;
      logic [9:0]  q;
      logic [7:0]  r;
      m = '0;
      q = '0;
      r = '0;
      case (dc)
         DIV_1: r = p[7:0];
         DIV_2: r = p[8:1];
         DIV_4: r = p[9:2];
         DIV_8: r = p[10:3];
         DIV_5: begin
            m = {12'd0, p[7:0]} * 20'd205;
            r = m[17:10];
         end
         DIV_6: begin
            q = {2'b00, p[8:1]};
            m = {10'd0, q} * 20'd683;
            r = m[18:11];
         end
         DIV_12: begin
            q = p[11:2];
            m = {10'd0, q} * 20'd683;
            r = m[18:11];
         end
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   lsfr_pixel_shader u_shader (
      .item      (item_ff),
      .pixel_idx (pix_ff),
      .shade     (shade)
   );

   // handshake and stage advance
   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s1_load    = item_valid_ff && (!s1_valid_ff || s2_load);
   assign last_load  = s1_load && (pix_ff == LAST_PIXEL);
   assign req_tready = !item_valid_ff || last_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      // start resets the cursor, advance steps it around the strip
      cursor_in = cursor_ff;
      if (req_accept) begin
         if (req_tuser[0] == CMD_START) begin
            cursor_in = 3'd0;
         end else if (cursor_ff >= LAST_PIXEL) begin
            cursor_in = 3'd0;
         end else begin
            cursor_in = cursor_ff + 3'd1;
         end
      end

      item_in = item_ff;
      if (req_accept) begin
         item_in.kind        = req_tuser[3:1];
         item_in.flow_right  = req_tdata[0];
         item_in.base.red    = req_tdata[8:1];
         item_in.base.green  = req_tdata[16:9];
         item_in.base.blue   = req_tdata[24:17];
         item_in.agent_state = req_tdata[27:25];
         item_in.cursor      = cursor_in;
      end

      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (last_load) begin
         item_valid_in = 1'b0;
      end

      pix_in = pix_ff;
      if (last_load) begin
         pix_in = 3'd0;
      end else if (s1_load) begin
         pix_in = pix_ff + 3'd1;
      end

      // channel times weight, divided in the next stage
      s1_valid_in = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s1_red_in   = {4'd0, shade.color.red}   * {8'd0, shade.numer};
      s1_green_in = {4'd0, shade.color.green} * {8'd0, shade.numer};
      s1_blue_in  = {4'd0, shade.color.blue}  * {8'd0, shade.numer};
      s1_div_in   = shade.div_code;
      s1_idx_in   = pix_ff;

      rsp_valid_in = s2_load ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
      rsp_rgb_in   = {scale_div(s1_blue_ff, s1_div_ff),
                      scale_div(s1_green_ff, s1_div_ff),
                      scale_div(s1_red_ff, s1_div_ff)};
      rsp_idx_in   = s1_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= 3'd0;
         item_valid_ff <= 1'b0;
         pix_ff        <= 3'd0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         item_valid_ff <= item_valid_in;
         pix_ff        <= pix_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (s1_load) begin
         s1_red_ff   <= s1_red_in;
         s1_green_ff <= s1_green_in;
         s1_blue_ff  <= s1_blue_in;
         s1_div_ff   <= s1_div_in;
         s1_idx_ff   <= s1_idx_in;
      end
      if (s2_load) begin
         rsp_rgb_ff <= rsp_rgb_in;
         rsp_idx_ff <= rsp_idx_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_rgb_ff, rsp_idx_ff};
   assign rsp_tlast  = (rsp_idx_ff == LAST_PIXEL);

   // cursor and pixel counter never leave the strip
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff <= LAST_PIXEL) && (pix_ff <= LAST_PIXEL))
      else $error("cursor or pixel counter out of range");

   // a new item only lands on a busy holder when its last pixel leaves
   a_item_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && item_valid_ff) |-> (s1_load && pix_ff == LAST_PIXEL))
      else $error("item overwritten before its frame was rendered");

   // the counter only moves while an item is held
   a_pix_idle: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> (pix_ff == 3'd0))
      else $error("pixel counter moved without an item");

   // pixels leave the product stage in strip order
   a_pix_order: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_idx_ff != LAST_PIXEL) |=> (!s1_valid_ff || s1_idx_ff != 3'd0))
      else $error("frame restarted before its last pixel");

endmodule

// ===== bench/led_strip_effect_frame_renderer_test.sv =====
`timescale 1ns / 1ps

module led_strip_effect_frame_renderer_test;
   import lsfr_pkg::*;

   // cycles with no item moving on either side before the run is called hung
   localparam int QUIET_LIMIT = 2000;

   // one frame command as the sender sees it
   typedef struct packed {
      logic       command;
      logic [2:0] kind;
      logic       flow_right;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] agent;
   } frame_command_type;

   // one rendered pixel as it leaves the block
   typedef struct packed {
      logic [2:0] pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       is_last;
   } strip_pixel_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // own copy of the renderer state and its lookup tables
   logic [2:0]  strip_cursor = '0;
   int unsigned flow_weight [5] = '{12, 7, 4, 2, 1};
   int unsigned pulse_weight [5] = '{5, 12, 7, 3, 1};
   // ripple divisor, phase major, 0 means dark
   int unsigned ripple_divisor [20] = '{0, 5, 1, 5, 0,
                                        4, 1, 2, 1, 4,
                                        1, 4, 0, 4, 1,
                                        4, 6, 8, 6, 4};
   // marquee palette, red green blue per entry
   int unsigned rainbow_rgb [21] = '{46, 0, 5,   46, 17, 0,  38, 35, 0,  0, 43, 11,
                                     0, 36, 43,  12, 0, 47,  42, 0, 36};
   // status glow color per agent state, idle is dark
   int unsigned agent_rgb [15] = '{0, 0, 0,   0, 0, 28,  30, 12, 0,
                                   0, 24, 5,  30, 0, 8};

   strip_pixel_type expected_pixels [$];
   int          mismatch_count = 0;
   int          frames_sent = 0;
   int          pixels_checked = 0;
   int          quiet_cycles = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;

   led_strip_effect_frame_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor(c*n/d), kept to one channel byte
   function automatic logic [7:0] scale_channel(input int unsigned c, input int unsigned n,
                                                input int unsigned d);
      return 8'((c * n) / d);
   endfunction

   // update the cursor and queue the five pixels this command renders
   task automatic predict_frame(input frame_command_type c);
      int unsigned cur, n, d, head, gap, slot, center;
      int unsigned col [3];
      strip_pixel_type px;
      if (c.command == CMD_START) strip_cursor = '0;
      else strip_cursor = 3'((strip_cursor + 1) % PIXEL_COUNT);
      cur = strip_cursor;
      center = PIXEL_COUNT / 2;
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         col[0] = c.red;
         col[1] = c.green;
         col[2] = c.blue;
         n = 0;
         d = 1;
         case (c.kind)
            KIND_SOLID: n = 1;
            KIND_RIPPLE: begin
               d = ripple_divisor[(cur % 4) * 5 + i];
               n = (d != 0) ? 1 : 0;
               if (d == 0) d = 1;
            end
            KIND_FLOW: begin
               // head runs up the strip for right, down for left
               head = c.flow_right ? cur : (PIXEL_COUNT - 1) - cur;
               gap = c.flow_right ? (head + PIXEL_COUNT - i) % PIXEL_COUNT
                                  : (i + PIXEL_COUNT - head) % PIXEL_COUNT;
               n = flow_weight[gap];
               d = 12;
            end
            KIND_PULSE: begin
               n = (i == center) ? pulse_weight[cur] : (pulse_weight[cur] * 2) / 3;
               d = 12;
            end
            KIND_RAINBOW: begin
               slot = (i + cur) % 7;
               for (int ch = 0; ch < 3; ch++) col[ch] = rainbow_rgb[slot * 3 + ch];
               n = 1;
            end
            KIND_AGENT: begin
               gap = (i > center) ? i - center : center - i;
               // states past failed glow dark
               for (int ch = 0; ch < 3; ch++)
                  col[ch] = (c.agent <= AGENT_FAILED) ? agent_rgb[c.agent * 3 + ch] : 0;
               n = 1;
               d = (gap == 0) ? 1 : (gap == 1) ? 2 : 4;
            end
            default: n = 0;   // none and the unused kind render black
         endcase
         px.pos     = 3'(i);
         px.red     = scale_channel(col[0], n, d);
         px.green   = scale_channel(col[1], n, d);
         px.blue    = scale_channel(col[2], n, d);
         px.is_last = (i == PIXEL_COUNT - 1);
         expected_pixels.push_back(px);
      end
   endtask

   // present one command, wait for the handshake, then predict its frame
   task automatic send_command(input frame_command_type c);
      while (sender_gaps && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {c.kind, c.command};
      req_tdata  <= {4'b0, c.agent, c.blue, c.green, c.red, c.flow_right};
      do @(posedge clock); while (!req_tready);
      predict_frame(c);
      frames_sent++;
   endtask

   task automatic wait_for_drain();
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // channel values lean toward the extremes
   function automatic logic [7:0] random_channel();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic frame_command_type random_command();
      frame_command_type c;
      c.command    = 1'($urandom);
      c.kind       = 3'($urandom_range(7));
      c.flow_right = 1'($urandom);
      c.red        = random_channel();
      c.green      = random_channel();
      c.blue       = random_channel();
      c.agent      = 3'($urandom_range(7));
      return c;
   endfunction

   function automatic frame_command_type make_command(input logic cmd,
                                                      input logic [2:0] kind,
                                                      input logic right, input logic [7:0] r,
                                                      input logic [7:0] g, input logic [7:0] b,
                                                      input logic [2:0] st);
      frame_command_type c;
      c.command    = cmd;
      c.kind       = kind;
      c.flow_right = right;
      c.red        = r;
      c.green      = g;
      c.blue       = b;
      c.agent      = st;
      return c;
   endfunction

   // extremes, every effect, cursor walks and every agent state
   task automatic test_directed();
      send_command(make_command(CMD_START, KIND_NONE, 1'b1, 8'hff, 8'hff, 8'hff, AGENT_FAILED));
      send_command(make_command(CMD_START, KIND_SOLID, 1'b0, 8'hff, 8'hff, 8'hff, 3'd7));
      send_command(make_command(CMD_START, KIND_SOLID, 1'b1, 8'hff, 8'h00, 8'haa, AGENT_IDLE));
      // unused kind 7 stays black even at full color
      send_command(make_command(CMD_START, 3'd7, 1'b1, 8'hff, 8'hff, 8'hff, AGENT_RUNNING));
      send_command(make_command(CMD_START, KIND_RIPPLE, 1'b0, 8'hff, 8'hff, 8'hff, AGENT_IDLE));
      repeat (3)
         send_command(make_command(CMD_ADVANCE, KIND_RIPPLE, 1'b1, 8'hff, 8'h80, 8'h01,
                                   AGENT_IDLE));
      send_command(make_command(CMD_START, KIND_FLOW, 1'b1, 8'hff, 8'hff, 8'hff, AGENT_IDLE));
      send_command(make_command(CMD_ADVANCE, KIND_FLOW, 1'b1, 8'hff, 8'h7f, 8'h00, AGENT_IDLE));
      send_command(make_command(CMD_START, KIND_FLOW, 1'b0, 8'hff, 8'hff, 8'hff, AGENT_IDLE));
      send_command(make_command(CMD_ADVANCE, KIND_FLOW, 1'b0, 8'h00, 8'hff, 8'h55, AGENT_IDLE));
      // pulse walks the cursor through 4 and back round to 0
      send_command(make_command(CMD_START, KIND_PULSE, 1'b0, 8'hff, 8'hff, 8'hff, AGENT_IDLE));
      repeat (5)
         send_command(make_command(CMD_ADVANCE, KIND_PULSE, 1'b0, 8'hff, 8'hc3, 8'h0c,
                                   AGENT_IDLE));
      send_command(make_command(CMD_START, KIND_RAINBOW, 1'b1, 8'h00, 8'h00, 8'h00, 3'd7));
      send_command(make_command(CMD_ADVANCE, KIND_RAINBOW, 1'b0, 8'hff, 8'hff, 8'hff,
                                AGENT_IDLE));
      // every agent state code, the unknown ones included
      for (int st = 0; st < 8; st++)
         send_command(make_command(CMD_START, KIND_AGENT, 1'(st), 8'hff, 8'hff, 8'hff,
                                   3'(st)));
   endtask

   // start an effect and let it run for a while, content random
   task automatic test_effect_runs(input int runs);
      frame_command_type c;
      for (int r = 0; r < runs; r++) begin
         c = random_command();
         c.command = CMD_START;
         c.kind = 3'($urandom_range(KIND_AGENT));
         if ($urandom_range(3) != 0) c.agent = 3'($urandom_range(AGENT_FAILED));
         send_command(c);
         repeat ($urandom_range(1, 8)) begin
            c.command = CMD_ADVANCE;
            if ($urandom_range(1) == 0) begin
               c.red   = random_channel();
               c.green = random_channel();
               c.blue  = random_channel();
            end
            send_command(c);
         end
      end
   endtask

   // fully random commands, broken runs and odd kinds included
   task automatic test_noise(input int count);
      repeat (count) send_command(random_command());
   endtask

   // no gaps and no stalls for a long stretch
   task automatic test_back_to_back(input int count);
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_effect_runs(count);
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // the sender holds off until the strip has drained
   task automatic test_drain_pause();
      test_noise(10);
      req_tvalid <= 1'b0;
      wait_for_drain();
      test_effect_runs(2);
   endtask

   // compare the pixel on the bus with the oldest expected one
   task automatic check_pixel();
      strip_pixel_type want;
      strip_pixel_type got;
      got.pos     = rsp_tdata[2:0];
      got.red     = rsp_tdata[10:3];
      got.green   = rsp_tdata[18:11];
      got.blue    = rsp_tdata[26:19];
      got.is_last = rsp_tlast;
      if (expected_pixels.size() == 0) begin
         $display("%0t: pixel with nothing expected, got pos %0d rgb %h %h %h last %b",
                  $time, got.pos, got.red, got.green, got.blue, got.is_last);
         mismatch_count++;
      end else begin
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.pos !== want.pos) begin
            $display("%0t: pixel index expected %0d got %0d", $time, want.pos, got.pos);
            mismatch_count++;
         end
         if (got.red !== want.red) begin
            $display("%0t: pixel %0d red expected %h got %h", $time, want.pos, want.red,
                     got.red);
            mismatch_count++;
         end
         if (got.green !== want.green) begin
            $display("%0t: pixel %0d green expected %h got %h", $time, want.pos, want.green,
                     got.green);
            mismatch_count++;
         end
         if (got.blue !== want.blue) begin
            $display("%0t: pixel %0d blue expected %h got %h", $time, want.pos, want.blue,
                     got.blue);
            mismatch_count++;
         end
         if (got.is_last !== want.is_last) begin
            $display("%0t: pixel %0d last expected %b got %b", $time, want.pos,
                     want.is_last, got.is_last);
            mismatch_count++;
         end
      end
   endtask

   // result side: sample at the edge, then pick the next ready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) check_pixel();
         rsp_tready <= !receiver_stalls || ($urandom_range(99) >= 21);
      end
   end

   // hang detector: any accepted item on either side restarts the count
   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d pixels outstanding", $time,
                     QUIET_LIMIT, expected_pixels.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_effect_runs(30);
      test_drain_pause();
      test_noise(70);
      test_back_to_back(8);
      test_effect_runs(6);
      req_tvalid <= 1'b0;
      wait_for_drain();
      // a few more cycles so a stray extra pixel would still be seen
      repeat (4 * PIXEL_COUNT) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
         mismatch_count++;
      end
      $display("%0d frame commands rendered, %0d pixels compared", frames_sent,
               pixels_checked);
      $display("all effects and the unused kind, both flow ways, cursor wrap, agent states");
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
